FILE: src/segmented_lru_cache_policy_core_macros.svh
// ----------------------------------------------------------------------------
// Segmented LRU policy core: assertion macros
// Simulation builds expand to concurrent assertions; synthesis sees nothing.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_LRU_CACHE_POLICY_CORE_MACROS_SVH
`define SEGMENTED_LRU_CACHE_POLICY_CORE_MACROS_SVH
`ifndef SYNTHESIS
// check a property outside reset
`define SLRU_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("slru assertion failed");
// check a property at every edge, reset included
`define SLRU_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("slru assertion failed");
`else
`define SLRU_ASSERT(lbl, ck, rs, prop)
`define SLRU_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

FILE: src/slru_pkg.sv
// ----------------------------------------------------------------------------
// Segmented LRU policy package
// Shared types, register indexes and segment codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package slru_pkg;

  localparam int KEY_W     = 32;
  localparam int CAP_W     = 9;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_CAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROT_CAP = 2'd2;

  // segment codes
  localparam logic SEG_PROB = 1'b0;
  localparam logic SEG_PROT = 1'b1;

  typedef struct packed {
    logic             enable;
    logic [CAP_W-1:0] prob_cap;
    logic [CAP_W-1:0] prot_cap;
  } cfg_t;

  // transaction queued between front and engine
  typedef struct packed {
    logic              dis;
    logic [KEY_W-1:0]  key;
  } q_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UNL_RD,
    S_UNL_WR,
    S_PUSH_A,
    S_PUSH_B,
    S_CHECK,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    ST_HIT_PROB,
    ST_HIT_PROT,
    ST_DEMOTE,
    ST_DEMOTE_PUSH,
    ST_TRIM,
    ST_INSERT,
    ST_FINISH
  } step_t;

endpackage

FILE: src/slru_if.sv
// ----------------------------------------------------------------------------
// Segmented LRU stream interfaces
// Request channel (one key) and response channel (one result).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface slru_req_if;
  logic                             valid;
  logic                             ready;
  logic signed [slru_pkg::KEY_W-1:0] access_key;

  modport source (output valid, output access_key, input ready);
  modport sink   (input valid, input access_key, output ready);
endinterface

interface slru_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             disabled;
  logic                             hit;
  logic                             hit_in_protected;
  logic                             evicted_valid;
  logic signed [slru_pkg::KEY_W-1:0] evicted_key;

  modport source (output valid, output disabled, output hit, output hit_in_protected,
                  output evicted_valid, output evicted_key, input ready);
  modport sink   (input valid, input disabled, input hit, input hit_in_protected,
                  input evicted_valid, input evicted_key, output ready);
endinterface

FILE: src/slru_front.sv
// ----------------------------------------------------------------------------
// Segmented LRU front end
// Accepts requests, tags disabled accesses and queues them for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module slru_front (
  input  logic                clk,
  input  logic                rst,
  input  slru_pkg::cfg_t      cfg,
  slru_req_if.sink            req,
  output logic                q_valid,
  output slru_pkg::q_item_t   q_data,
  input  logic                q_pop
);

  slru_pkg::q_item_t slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              push;

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (fill != 2'd0);
  assign q_data    = slot[rd_ptr];

  // store classified transaction
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr].dis <= !cfg.enable;
      slot[wr_ptr].key <= req.access_key;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop && q_valid) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop && q_valid);
    end
  end

endmodule

FILE: src/slru_engine.sv
// ----------------------------------------------------------------------------
// Segmented LRU engine
// Scans the key store, relinks the recency lists and drives the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segmented_lru_cache_policy_core_macros.svh"
module slru_engine #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  slru_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  slru_pkg::q_item_t   q_data,
  output logic                q_pop,
  slru_rsp_if.source          rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (KEY_BITS < slru_pkg::KEY_W) ? KEY_BITS : slru_pkg::KEY_W;
  localparam int MW = (CW > slru_pkg::CAP_W) ? CW : slru_pkg::CAP_W;

  // memories
  logic [KW-1:0] key_mem  [CAPACITY];
  logic [IW-1:0] next_mem [CAPACITY];
  logic [IW-1:0] prev_mem [CAPACITY];

  logic [IW-1:0] key_ra, key_wa, nx_wa, pv_wa;
  logic [KW-1:0] key_rd, key_wd;
  logic [IW-1:0] nx_rd, pv_rd, nx_wd, pv_wd;
  logic          key_we, nx_we, pv_we;

  // control and list state
  slru_pkg::state_t state, state_next;
  slru_pkg::step_t  step, step_next;
  logic              op_seg, op_seg_next;
  logic [IW-1:0]     op_idx, op_idx_next;
  logic              op_evict, op_evict_next;
  logic [IW-1:0]     head [2];
  logic [IW-1:0]     head_next [2];
  logic [IW-1:0]     tail [2];
  logic [IW-1:0]     tail_next [2];
  logic [CW-1:0]     cnt [2];
  logic [CW-1:0]     cnt_next [2];
  logic [CAPACITY-1:0] valid_bits, valid_bits_next;
  logic [CAPACITY-1:0] seg_bits, seg_bits_next;
  logic [CW-1:0]     scnt, scnt_next;
  logic              cmp_v;
  logic [IW-1:0]     cmp_idx;
  logic              found_v, found_v_next;
  logic [IW-1:0]     found_idx, found_idx_next;
  logic              free_v, free_v_next;
  logic [IW-1:0]     free_idx, free_idx_next;
  logic [KW-1:0]     cur_key, cur_key_next;
  logic              cur_dis, cur_dis_next;
  logic              hit, hit_next;
  logic              hit_prot, hit_prot_next;
  logic              ev_v, ev_v_next;
  logic [KW-1:0]     ev_key, ev_key_next;
  logic [63:0]       request_counter, request_counter_next;
  logic [63:0]       hit_counter, hit_counter_next;
  logic [63:0]       miss_counter, miss_counter_next;
  logic              out_v, out_v_next;
  logic              out_load;
  logic [MW-1:0]     prob_cap_x, prot_cap_x;
  logic [MW-1:0]     cnt_prob_x, cnt_prot_x;

  assign prob_cap_x = MW'(cfg.prob_cap);
  assign prot_cap_x = MW'(cfg.prot_cap);
  assign cnt_prob_x = MW'(cnt[slru_pkg::SEG_PROB]);
  assign cnt_prot_x = MW'(cnt[slru_pkg::SEG_PROT]);

  // memory ports
  always_ff @(posedge clk) begin
    key_rd <= key_mem[key_ra];
    nx_rd  <= next_mem[op_idx];
    pv_rd  <= prev_mem[op_idx];
    if (key_we) key_mem[key_wa]  <= key_wd;
    if (nx_we)  next_mem[nx_wa] <= nx_wd;
    if (pv_we)  prev_mem[pv_wa] <= pv_wd;
  end

  // track which scan entry the key read data belongs to
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_v <= 1'b0;
    end else begin
      cmp_v <= (state == slru_pkg::S_SCAN) && (scnt < CW'(CAPACITY));
    end
    cmp_idx <= scnt[IW-1:0];
  end

  // sequencer: next state, list updates and memory writes
  always_comb begin
    state_next           = state;
    step_next            = step;
    op_seg_next          = op_seg;
    op_idx_next          = op_idx;
    op_evict_next        = op_evict;
    head_next            = head;
    tail_next            = tail;
    cnt_next             = cnt;
    valid_bits_next      = valid_bits;
    seg_bits_next        = seg_bits;
    scnt_next            = scnt;
    found_v_next         = found_v;
    found_idx_next       = found_idx;
    free_v_next          = free_v;
    free_idx_next        = free_idx;
    cur_key_next         = cur_key;
    cur_dis_next         = cur_dis;
    hit_next             = hit;
    hit_prot_next        = hit_prot;
    ev_v_next            = ev_v;
    ev_key_next          = ev_key;
    request_counter_next = request_counter;
    hit_counter_next     = hit_counter;
    miss_counter_next    = miss_counter;
    q_pop                = 1'b0;
    out_load             = 1'b0;
    key_ra               = op_idx;
    key_we               = 1'b0;
    key_wa               = free_idx;
    key_wd               = cur_key;
    nx_we                = 1'b0;
    nx_wa                = op_idx;
    nx_wd                = op_idx;
    pv_we                = 1'b0;
    pv_wa                = op_idx;
    pv_wd                = op_idx;

    case (state)
      // take the next queued transaction
      slru_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          cur_key_next   = q_data.key[KW-1:0];
          cur_dis_next   = q_data.dis;
          hit_next       = 1'b0;
          hit_prot_next  = 1'b0;
          ev_v_next      = 1'b0;
          ev_key_next    = '0;
          found_v_next   = 1'b0;
          free_v_next    = 1'b0;
          scnt_next      = '0;
          if (q_data.dis) begin
            state_next = slru_pkg::S_FINISH;
          end else begin
            request_counter_next = request_counter + 64'd1;
            state_next           = slru_pkg::S_SCAN;
          end
        end
      end

      // walk the key store, one entry a cycle
      slru_pkg::S_SCAN: begin
        key_ra = scnt[IW-1:0];
        if (scnt < CW'(CAPACITY)) scnt_next = scnt + CW'(1);
        if (cmp_v) begin
          if (valid_bits[cmp_idx]) begin
            if (!found_v && key_rd == cur_key) begin
              found_v_next   = 1'b1;
              found_idx_next = cmp_idx;
            end
          end else if (!free_v) begin
            free_v_next   = 1'b1;
            free_idx_next = cmp_idx;
          end
        end
        if (scnt == CW'(CAPACITY)) state_next = slru_pkg::S_DECIDE;
      end

      // classify hit or miss and start the first list operation
      slru_pkg::S_DECIDE: begin
        if (found_v) begin
          hit_next         = 1'b1;
          hit_counter_next = hit_counter + 64'd1;
          op_idx_next      = found_idx;
          op_evict_next    = 1'b0;
          state_next       = slru_pkg::S_UNL_RD;
          if (seg_bits[found_idx] == slru_pkg::SEG_PROB) begin
            op_seg_next = slru_pkg::SEG_PROB;
            step_next   = slru_pkg::ST_HIT_PROB;
          end else begin
            hit_prot_next = 1'b1;
            op_seg_next   = slru_pkg::SEG_PROT;
            step_next     = slru_pkg::ST_HIT_PROT;
          end
        end else begin
          miss_counter_next = miss_counter + 64'd1;
          step_next         = slru_pkg::ST_INSERT;
          if (free_v) begin
            state_next = slru_pkg::S_CHECK;
          end else begin
            // store full: evict probation tail, or protected tail if probation is empty
            op_seg_next   = (cnt[slru_pkg::SEG_PROB] != '0) ? slru_pkg::SEG_PROB
                                                            : slru_pkg::SEG_PROT;
            op_idx_next   = (cnt[slru_pkg::SEG_PROB] != '0) ? tail[slru_pkg::SEG_PROB]
                                                            : tail[slru_pkg::SEG_PROT];
            op_evict_next = 1'b1;
            state_next    = slru_pkg::S_UNL_RD;
          end
        end
      end

      // unlink: links and key of the entry arrive next cycle
      slru_pkg::S_UNL_RD: begin
        key_ra     = op_idx;
        state_next = slru_pkg::S_UNL_WR;
      end

      slru_pkg::S_UNL_WR: begin
        if (cnt[op_seg] != '0) begin
          if (op_idx == head[op_seg]) begin
            head_next[op_seg] = nx_rd;
          end else begin
            nx_we = 1'b1;
            nx_wa = pv_rd;
            nx_wd = nx_rd;
          end
          if (op_idx == tail[op_seg]) begin
            tail_next[op_seg] = pv_rd;
          end else begin
            pv_we = 1'b1;
            pv_wa = nx_rd;
            pv_wd = pv_rd;
          end
          cnt_next[op_seg] = cnt[op_seg] - CW'(1);
          if (op_evict) begin
            valid_bits_next[op_idx] = 1'b0;
            ev_v_next               = 1'b1;
            ev_key_next             = key_rd;
            free_idx_next           = op_idx;
          end
        end
        state_next = slru_pkg::S_CHECK;
      end

      // push front, first half: forward link and old head's back link
      slru_pkg::S_PUSH_A: begin
        nx_we = 1'b1;
        nx_wa = op_idx;
        nx_wd = head[op_seg];
        if (cnt[op_seg] != '0) begin
          pv_we = 1'b1;
          pv_wa = head[op_seg];
          pv_wd = op_idx;
        end
        state_next = slru_pkg::S_PUSH_B;
      end

      // push front, second half: own back link and list head
      slru_pkg::S_PUSH_B: begin
        pv_we = 1'b1;
        pv_wa = op_idx;
        pv_wd = op_idx;
        if (cnt[op_seg] == '0) tail_next[op_seg] = op_idx;
        head_next[op_seg]     = op_idx;
        cnt_next[op_seg]      = cnt[op_seg] + CW'(1);
        seg_bits_next[op_idx] = op_seg;
        state_next            = slru_pkg::S_CHECK;
      end

      // choose the next list operation
      slru_pkg::S_CHECK: begin
        op_evict_next = 1'b0;
        case (step)
          slru_pkg::ST_HIT_PROB: begin
            op_idx_next = found_idx;
            state_next  = slru_pkg::S_PUSH_A;
            if (cfg.prot_cap == '0) begin
              op_seg_next = slru_pkg::SEG_PROB;
              step_next   = slru_pkg::ST_FINISH;
            end else begin
              op_seg_next = slru_pkg::SEG_PROT;
              step_next   = slru_pkg::ST_DEMOTE;
            end
          end
          slru_pkg::ST_HIT_PROT: begin
            op_idx_next = found_idx;
            op_seg_next = slru_pkg::SEG_PROT;
            state_next  = slru_pkg::S_PUSH_A;
            step_next   = slru_pkg::ST_FINISH;
          end
          slru_pkg::ST_DEMOTE: begin
            if (cnt_prot_x > prot_cap_x) begin
              op_seg_next = slru_pkg::SEG_PROT;
              op_idx_next = tail[slru_pkg::SEG_PROT];
              state_next  = slru_pkg::S_UNL_RD;
              step_next   = slru_pkg::ST_DEMOTE_PUSH;
            end else begin
              step_next = slru_pkg::ST_TRIM;
            end
          end
          slru_pkg::ST_DEMOTE_PUSH: begin
            op_seg_next = slru_pkg::SEG_PROB;
            state_next  = slru_pkg::S_PUSH_A;
            step_next   = slru_pkg::ST_DEMOTE;
          end
          slru_pkg::ST_TRIM: begin
            if (cnt_prob_x > prob_cap_x) begin
              op_seg_next   = slru_pkg::SEG_PROB;
              op_idx_next   = tail[slru_pkg::SEG_PROB];
              op_evict_next = 1'b1;
              state_next    = slru_pkg::S_UNL_RD;
            end else begin
              step_next = slru_pkg::ST_FINISH;
            end
          end
          slru_pkg::ST_INSERT: begin
            key_we                    = 1'b1;
            valid_bits_next[free_idx] = 1'b1;
            op_seg_next               = slru_pkg::SEG_PROB;
            op_idx_next               = free_idx;
            state_next                = slru_pkg::S_PUSH_A;
            step_next                 = slru_pkg::ST_TRIM;
          end
          slru_pkg::ST_FINISH: begin
            state_next = slru_pkg::S_FINISH;
          end
          default: begin
            state_next = slru_pkg::S_FINISH;
          end
        endcase
      end

      // hand the result to the output register
      slru_pkg::S_FINISH: begin
        if (!out_v || rsp.ready) begin
          out_load   = 1'b1;
          state_next = slru_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = slru_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_v_next = out_v;
    if (rsp.ready) out_v_next = 1'b0;
    if (out_load)  out_v_next = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= slru_pkg::S_IDLE;
      step            <= slru_pkg::ST_FINISH;
      cnt[0]          <= '0;
      cnt[1]          <= '0;
      valid_bits      <= '0;
      seg_bits        <= '0;
      request_counter <= '0;
      hit_counter     <= '0;
      miss_counter    <= '0;
      out_v           <= 1'b0;
    end else begin
      state           <= state_next;
      step            <= step_next;
      cnt             <= cnt_next;
      valid_bits      <= valid_bits_next;
      seg_bits        <= seg_bits_next;
      request_counter <= request_counter_next;
      hit_counter     <= hit_counter_next;
      miss_counter    <= miss_counter_next;
      out_v           <= out_v_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_seg    <= op_seg_next;
    op_idx    <= op_idx_next;
    op_evict  <= op_evict_next;
    head      <= head_next;
    tail      <= tail_next;
    scnt      <= scnt_next;
    found_v   <= found_v_next;
    found_idx <= found_idx_next;
    free_v    <= free_v_next;
    free_idx  <= free_idx_next;
    cur_key   <= cur_key_next;
    cur_dis   <= cur_dis_next;
    hit       <= hit_next;
    hit_prot  <= hit_prot_next;
    ev_v      <= ev_v_next;
    ev_key    <= ev_key_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.disabled         <= cur_dis;
      rsp.hit              <= hit;
      rsp.hit_in_protected <= hit_prot;
      rsp.evicted_valid    <= ev_v;
      rsp.evicted_key      <= slru_pkg::KEY_W'(ev_key);
    end
  end

  assign rsp.valid = out_v;

  `SLRU_ASSERT_ALWAYS(a_occupancy_bound, clk, rst || ((CW+1)'(cnt[0]) + (CW+1)'(cnt[1]) <= (CW+1)'(CAPACITY)))
  `SLRU_ASSERT(a_idle_waits, clk, rst, (state == slru_pkg::S_IDLE && !q_valid) |=> (state == slru_pkg::S_IDLE))
  `SLRU_ASSERT(a_load_from_finish, clk, rst, $rose(out_v) |-> ($past(state) == slru_pkg::S_FINISH))
  `SLRU_ASSERT(a_prot_hit_is_hit, clk, rst, (state == slru_pkg::S_FINISH && hit_prot) |-> (hit && !cur_dis))

endmodule

FILE: src/segmented_lru_cache_policy_core.sv
// ----------------------------------------------------------------------------
// Segmented LRU cache policy core
// Two-segment LRU replacement engine with configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one access_key per transaction; rsp returns one result per
//   request, in order. cfg_we/cfg_index/cfg_data write cache_enable (0),
//   probation_capacity (1) and protected_capacity (2) while nothing is in flight.
// Timing:
//   The key store is scanned one entry a cycle, then the lists are relinked.
//   Promotions, demotions and evictions add relink steps before rsp.valid rises;
//   a disabled access skips the scan and relinking. One request is processed at
//   a time; a two-entry queue takes new requests while the engine works.
// Reset:
//   Lists empty, entries invalid, counters zero, enabled, capacities 64 and 192.
// Backpressure:
//   A result waits in the output register while rsp.ready is low; the engine
//   holds its next result and the request queue fills, then req.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module segmented_lru_cache_policy_core #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [slru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slru_pkg::CAP_W-1:0]          cfg_data,
  slru_req_if.sink                            req,
  slru_rsp_if.source                          rsp
);

  slru_pkg::cfg_t    cfg;
  logic              q_valid;
  logic              q_pop;
  slru_pkg::q_item_t q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable   <= 1'b1;
      cfg.prob_cap <= slru_pkg::CAP_W'(64);
      cfg.prot_cap <= slru_pkg::CAP_W'(192);
    end else if (cfg_we) begin
      case (cfg_index)
        slru_pkg::REG_ENABLE:   cfg.enable   <= cfg_data[0];
        slru_pkg::REG_PROB_CAP: cfg.prob_cap <= cfg_data;
        slru_pkg::REG_PROT_CAP: cfg.prot_cap <= cfg_data;
        default: ;
      endcase
    end
  end

  slru_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .req     (req),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  slru_engine #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented LRU policy core testbench
// Drives key accesses through the request channel under several capacity and
// enable settings. A behavioral copy of the two-segment LRU predicts every
// response, and each response is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_ENTRIES = 256;
  localparam int POOL_SIZE   = 512;
  localparam int DRAIN_WAIT  = 400;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct {
    bit                         dis;
    bit                         hit;
    bit                         hit_prot;
    bit                         ev_valid;
    logic [slru_pkg::KEY_W-1:0] ev_key;
  } access_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [slru_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [slru_pkg::CAP_W-1:0] cfg_data;

  slru_req_if req ();
  slru_rsp_if rsp ();

  segmented_lru_cache_policy_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  // stimulus and expectations
  logic [slru_pkg::KEY_W-1:0] pending_keys[$];
  access_result_t expected_results[$];
  logic [slru_pkg::KEY_W-1:0] key_pool[POOL_SIZE];
  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  longint cycle_count;
  bit req_taken;

  // shadow cache state
  logic [slru_pkg::KEY_W-1:0] sh_key[NUM_ENTRIES];
  bit sh_valid[NUM_ENTRIES];
  bit sh_seg[NUM_ENTRIES];
  int unsigned sh_next[NUM_ENTRIES];
  int unsigned sh_prev[NUM_ENTRIES];
  int unsigned seg_head[2];
  int unsigned seg_tail[2];
  int unsigned seg_count[2];
  bit sh_enable;
  int unsigned sh_prob_cap;
  int unsigned sh_prot_cap;
  bit ev_seen;
  logic [slru_pkg::KEY_W-1:0] ev_last;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  function void seg_unlink(int s, int unsigned i);
    if (seg_count[s] == 0) return;
    if (i == seg_head[s]) seg_head[s] = sh_next[i];
    else sh_next[sh_prev[i] % NUM_ENTRIES] = sh_next[i];
    if (i == seg_tail[s]) seg_tail[s] = sh_prev[i];
    else sh_prev[sh_next[i] % NUM_ENTRIES] = sh_prev[i];
    seg_count[s]--;
  endfunction

  function void seg_push_front(int s, int unsigned i);
    sh_next[i] = seg_head[s];
    sh_prev[i] = i;
    if (seg_count[s] == 0) seg_tail[s] = i;
    else sh_prev[seg_head[s] % NUM_ENTRIES] = i;
    seg_head[s] = i;
    seg_count[s]++;
    sh_seg[i] = s[0];
  endfunction

  function void seg_evict_tail(int s);
    int unsigned i;
    if (seg_count[s] == 0) return;
    i = seg_tail[s] % NUM_ENTRIES;
    seg_unlink(s, i);
    sh_valid[i] = 1'b0;
    ev_seen = 1'b1;
    ev_last = sh_key[i];
  endfunction

  function void trim_probation();
    while (seg_count[slru_pkg::SEG_PROB] > sh_prob_cap) seg_evict_tail(slru_pkg::SEG_PROB);
  endfunction

  // compute the response of one access and update the shadow state
  function access_result_t lookup_and_update(logic [slru_pkg::KEY_W-1:0] key);
    access_result_t r;
    int unsigned found, free_slot, d;
    r = '{default: '0};
    ev_seen = 1'b0;
    ev_last = '0;
    found = NUM_ENTRIES;
    free_slot = NUM_ENTRIES;
    if (!sh_enable) begin
      r.dis = 1'b1;
      return r;
    end
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (sh_valid[i]) begin
        if (found == NUM_ENTRIES && sh_key[i] == key) found = i;
      end else if (free_slot == NUM_ENTRIES) begin
        free_slot = i;
      end
    end
    if (found < NUM_ENTRIES) begin
      r.hit = 1'b1;
      if (sh_seg[found] == slru_pkg::SEG_PROB) begin
        seg_unlink(slru_pkg::SEG_PROB, found);
        if (sh_prot_cap == 0) begin
          seg_push_front(slru_pkg::SEG_PROB, found);
        end else begin
          seg_push_front(slru_pkg::SEG_PROT, found);
          // demote protected tails while over capacity
          while (seg_count[slru_pkg::SEG_PROT] > sh_prot_cap) begin
            d = seg_tail[slru_pkg::SEG_PROT] % NUM_ENTRIES;
            seg_unlink(slru_pkg::SEG_PROT, d);
            seg_push_front(slru_pkg::SEG_PROB, d);
          end
          trim_probation();
        end
      end else begin
        r.hit_prot = 1'b1;
        seg_unlink(slru_pkg::SEG_PROT, found);
        seg_push_front(slru_pkg::SEG_PROT, found);
      end
    end else begin
      if (free_slot >= NUM_ENTRIES) begin
        seg_evict_tail(seg_count[slru_pkg::SEG_PROB] > 0 ? slru_pkg::SEG_PROB
                                                          : slru_pkg::SEG_PROT);
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (!sh_valid[i]) begin
            free_slot = i;
            break;
          end
        end
      end
      if (free_slot < NUM_ENTRIES) begin
        sh_key[free_slot] = key;
        sh_valid[free_slot] = 1'b1;
        seg_push_front(slru_pkg::SEG_PROB, free_slot);
      end
      trim_probation();
    end
    r.ev_valid = ev_seen;
    r.ev_key = ev_seen ? ev_last : '0;
    return r;
  endfunction

  task report_mismatch(string what, logic [slru_pkg::KEY_W-1:0] got,
                       logic [slru_pkg::KEY_W-1:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // request driver: hold valid until the transaction is taken
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (pending_keys.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req.valid <= 1'b1;
        req.access_key <= pending_keys[0];
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // request acceptance: predict and flag the taken transaction
  always @(posedge clk) begin
    req_taken <= !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready) begin
      expected_results.push_back(lookup_and_update(pending_keys.pop_front()));
    end
  end

  // response ready with random stalls
  always @(negedge clk) begin
    rsp.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // response monitor
  always @(posedge clk) begin
    access_result_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected response", rsp.evicted_key, '0);
      end else begin
        e = expected_results.pop_front();
        if (rsp.disabled !== e.dis)
          report_mismatch("disabled", slru_pkg::KEY_W'(rsp.disabled), slru_pkg::KEY_W'(e.dis));
        if (rsp.hit !== e.hit)
          report_mismatch("hit", slru_pkg::KEY_W'(rsp.hit), slru_pkg::KEY_W'(e.hit));
        if (rsp.hit_in_protected !== e.hit_prot)
          report_mismatch("hit_in_protected", slru_pkg::KEY_W'(rsp.hit_in_protected),
                          slru_pkg::KEY_W'(e.hit_prot));
        if (rsp.evicted_valid !== e.ev_valid)
          report_mismatch("evicted_valid", slru_pkg::KEY_W'(rsp.evicted_valid),
                          slru_pkg::KEY_W'(e.ev_valid));
        if (rsp.evicted_key !== e.ev_key)
          report_mismatch("evicted_key", rsp.evicted_key, e.ev_key);
      end
    end
  end

  task write_reg(logic [slru_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[slru_pkg::CAP_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == slru_pkg::REG_ENABLE) sh_enable = value[0];
    else if (idx == slru_pkg::REG_PROB_CAP) sh_prob_cap = value & 32'h1FF;
    else if (idx == slru_pkg::REG_PROT_CAP) sh_prot_cap = value & 32'h1FF;
  endtask

  task wait_drained();
    while (pending_keys.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // program all registers, then queue random accesses from a key pool
  task run_phase(int en, int prob, int prot, int n_items, int pool_n, int mode);
    wait_drained();
    write_reg(slru_pkg::REG_ENABLE, en);
    write_reg(slru_pkg::REG_PROB_CAP, prob);
    write_reg(slru_pkg::REG_PROT_CAP, prot);
    send_idle_pct  = (mode == 1) ? 56 : (mode == 3) ? 22 : 0;
    recv_stall_pct = (mode == 2) ? 56 : (mode == 3) ? 22 : 0;
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) < 8) pending_keys.push_back($urandom);
      else pending_keys.push_back(key_pool[$urandom_range(0, pool_n - 1)]);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.access_key = '0;
    rsp.ready = 1'b0;
    req_taken = 1'b0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      sh_valid[i] = 1'b0;
      sh_seg[i] = 1'b0;
      sh_key[i] = '0;
      sh_next[i] = 0;
      sh_prev[i] = 0;
    end
    seg_head = '{0, 0};
    seg_tail = '{0, 0};
    seg_count = '{0, 0};
    sh_enable = 1'b1;
    sh_prob_cap = 64;
    sh_prot_cap = 192;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: key extremes, probation hit, protected hit, reset capacities
    pending_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'hAAAA_AAAA};
    // directed: zero probation capacity evicts the inserted key at once
    run_phase(1, 0, 2, 0, 1, 0);
    pending_keys = '{32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFFE};
    // directed: disabled accesses change nothing
    run_phase(0, 64, 192, 0, 1, 0);
    pending_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678};

    // random phases across capacity settings and idle patterns
    run_phase(1, 64, 192, 120, 40, 0);
    run_phase(1, 8, 0, 110, 16, 1);
    run_phase(1, 0, 4, 90, 8, 2);
    run_phase(0, 5, 5, 40, 8, 3);
    run_phase(1, 256, 256, 330, POOL_SIZE, 0);
    run_phase(1, 3, 2, 110, 6, 1);
    run_phase(1, 1, 1, 90, 4, 2);
    run_phase(1, 256, 0, 60, 300, 3);
    run_phase(1, 2, 256, 60, 10, 0);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
